@@ rtl/jsr_pkg.sv @@
// shared types and constants for the jog speed ramp with load guard
// no dependencies; imported by jsr_div and the top level
`default_nettype none

package jsr_pkg;

    localparam int unsigned CFG_DATA_W  = 23;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned RAMP_W      = 12;
    localparam int unsigned LOAD_W      = 24;
    localparam int unsigned THRESH_W    = 23;
    localparam int unsigned DEN_W       = 16;
    localparam int unsigned PROD_W      = 2 * SPEED_W;

    localparam logic [CFG_INDEX_W-1:0] REG_UP_MAX     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UP_RAMP    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DOWN_MAX   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DOWN_RAMP  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GUARD_EN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GUARD_THR  = 3'd5;

    localparam logic [RAMP_W-1:0]   RAMP_RESET   = 12'd1;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 23'h7FFFFF;

    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // per-direction jog sequencer phase; code 3 behaves like idle
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_RAMP  = 2'd2
    } phase_t;

    // block sequencer
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SEL  = 2'd1,
        S_DIV  = 2'd2,
        S_OUT  = 2'd3
    } state_t;

endpackage

`default_nettype wire

@@ rtl/jsr_div.sv @@
// shared multiply-then-divide unit: quotient = (a * b) / den, one bit per cycle
// uses jsr_pkg; caller guarantees a * b < 2^16 * den
`default_nettype none

module jsr_div
    import jsr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [SPEED_W-1:0] a,
    input  wire logic [SPEED_W-1:0] b,
    input  wire logic [DEN_W-1:0]   den,
    output logic                    done,
    output logic [SPEED_W-1:0]      quotient
);

    localparam int unsigned CNT_W = $clog2(SPEED_W + 1);

    logic [SPEED_W-1:0] a_reg;
    logic [SPEED_W-1:0] b_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PROD_W-1:0]  work_reg;
    logic [PROD_W-1:0]  work_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               mul_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DEN_W:0]     trial;
    logic [DEN_W:0]     diff;
    logic [SPEED_W-1:0] low_shift;

    // one restoring step: upper half holds the partial remainder
    always_comb
    begin
        trial     = {work_reg[PROD_W-1:SPEED_W], work_reg[SPEED_W-1]};
        low_shift = {work_reg[SPEED_W-2:0], 1'b0};
        diff      = trial - {1'b0, den_reg};
        if (trial >= {1'b0, den_reg})
        begin
            work_next = {diff[DEN_W-1:0], low_shift[SPEED_W-1:1], 1'b1};
        end
        else
        begin
            work_next = {trial[DEN_W-1:0], low_shift};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                mul_reg  <= 1'b0;
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SPEED_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            den_reg <= den;
        end
        if (mul_reg)
        begin
            work_reg <= a_reg * b_reg;
        end
        else if (busy_reg)
        begin
            work_reg <= work_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[SPEED_W-1:0];

endmodule

`default_nettype wire

@@ rtl/jog_speed_ramp_with_load_guard_top.sv @@
// top level of the jog speed ramp with load guard
// uses jsr_pkg and the shared divider jsr_div
`default_nettype none

// One input beat is one 100 ms jog tick carrying both holds and a load sample.
// Each held direction yields one result beat, up first then down, and last
// marks the final one; a tick with neither hold yields nothing. The input
// side stalls from acceptance until both directions are done; when down is
// released, that is once the select state that follows the last result beat
// is left. A released direction passes only through the select state; a
// direction in its idle or start phase, at full speed, or tripping goes on
// to present a result beat; a ramp step that needs a divide first waits on the
// shared multiply-divide unit (one operand latch, one multiply, 16 restoring
// steps, one result load). Any output stall makes a tick take longer.
// Configuration writes land at once and take no time.
module jog_speed_ramp_with_load_guard_top
    import jsr_pkg::*;
#(
    parameter int unsigned TICK_COUNT_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   up_held,
    input  wire logic                   down_held,
    input  wire logic signed [LOAD_W-1:0] load_sample,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        direction,
    output logic                        speed_valid,
    output logic [SPEED_W-1:0]          speed_cmd,
    output logic                        start_pulse,
    output logic                        stop_pulse,
    output logic                        guard_trip,
    output logic                        last
);

    localparam int unsigned TB = TICK_COUNT_BITS;
    localparam int unsigned CW = (TB > DEN_W) ? TB : DEN_W;

    // configuration
    logic [SPEED_W-1:0]  up_max_reg;
    logic [RAMP_W-1:0]   up_ramp_reg;
    logic [SPEED_W-1:0]  down_max_reg;
    logic [RAMP_W-1:0]   down_ramp_reg;
    logic                guard_en_reg;
    logic [THRESH_W-1:0] guard_thr_reg;

    // sequencer state
    state_t              state_reg, state_next;
    logic                dir_reg, dir_next;
    logic                up_held_reg;
    logic                down_held_reg;
    logic [LOAD_W-1:0]   mag_reg;
    phase_t              up_phase_reg, up_phase_next;
    phase_t              down_phase_reg, down_phase_next;
    logic [TB-1:0]       up_ticks_reg, up_ticks_next;
    logic [TB-1:0]       down_ticks_reg, down_ticks_next;

    // result beat
    logic                speed_valid_reg, speed_valid_next;
    logic [SPEED_W-1:0]  speed_reg, speed_next;
    logic                start_reg, start_next;
    logic                stop_reg, stop_next;
    logic                trip_reg, trip_next;
    logic                last_reg, last_next;

    // current direction view
    logic                in_accept;
    logic                out_accept;
    logic                cur_held;
    phase_t              cur_phase;
    logic [TB-1:0]       cur_ticks;
    logic [TB-1:0]       ticks_inc;
    logic [SPEED_W-1:0]  cur_max;
    logic [RAMP_W-1:0]   cur_ramp;
    logic [DEN_W-1:0]    den;
    logic                full_speed;
    logic                trip;
    logic [LOAD_W-1:0]   mag_in;

    // divider
    logic                div_start;
    logic [SPEED_W-1:0]  div_b;
    logic                div_done;
    logic [SPEED_W-1:0]  div_quo;

    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid && !out_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);

    assign mag_in = load_sample[LOAD_W-1] ? (LOAD_W'(0) - load_sample) : load_sample;

    assign cur_held  = dir_reg ? down_held_reg : up_held_reg;
    assign cur_phase = dir_reg ? down_phase_reg : up_phase_reg;
    assign cur_ticks = dir_reg ? down_ticks_reg : up_ticks_reg;
    assign cur_max   = dir_reg ? down_max_reg : up_max_reg;
    assign cur_ramp  = dir_reg ? down_ramp_reg : up_ramp_reg;

    assign ticks_inc  = (cur_ticks == {TB{1'b1}}) ? cur_ticks : cur_ticks + 1'b1;
    assign den        = {1'b0, cur_ramp, 3'b000} + {3'b000, cur_ramp, 1'b0};
    assign full_speed = (den == '0) || (CW'(ticks_inc) >= CW'(den));
    assign trip       = guard_en_reg && (mag_reg >= {1'b0, guard_thr_reg});
    // below full speed the count is under den, so its low 16 bits are exact
    assign div_b      = SPEED_W'(CW'(ticks_inc));

    jsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .a        (cur_max),
        .b        (div_b),
        .den      (den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        dir_next   = dir_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_SEL;
                    dir_next   = DIR_UP;
                end
            end
            S_SEL:
            begin
                if (!cur_held)
                begin
                    if (dir_reg == DIR_UP)
                    begin
                        dir_next = DIR_DOWN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (cur_phase == PH_RAMP && !trip && !full_speed)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_accept)
                begin
                    if (dir_reg == DIR_UP)
                    begin
                        state_next = S_SEL;
                        dir_next   = DIR_DOWN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and result fields
    always_comb
    begin
        phase_t        ph_new;
        logic [TB-1:0] tk_new;

        ph_new           = cur_phase;
        tk_new           = cur_ticks;
        up_phase_next    = up_phase_reg;
        down_phase_next  = down_phase_reg;
        up_ticks_next    = up_ticks_reg;
        down_ticks_next  = down_ticks_reg;
        speed_valid_next = speed_valid_reg;
        speed_next       = speed_reg;
        start_next       = start_reg;
        stop_next        = stop_reg;
        trip_next        = trip_reg;
        last_next        = last_reg;
        div_start        = 1'b0;

        if (state_reg == S_SEL)
        begin
            speed_valid_next = 1'b0;
            speed_next       = '0;
            start_next       = 1'b0;
            stop_next        = 1'b0;
            trip_next        = 1'b0;
            last_next        = (dir_reg == DIR_DOWN) || !down_held_reg;
            if (!cur_held)
            begin
                ph_new = PH_IDLE;
                tk_new = '0;
            end
            else
            begin
                case (cur_phase)
                    PH_START:
                    begin
                        start_next = 1'b1;
                        ph_new     = PH_RAMP;
                    end
                    PH_RAMP:
                    begin
                        speed_valid_next = 1'b1;
                        if (trip)
                        begin
                            stop_next = 1'b1;
                            trip_next = 1'b1;
                            ph_new    = PH_IDLE;
                            tk_new    = '0;
                        end
                        else
                        begin
                            tk_new = ticks_inc;
                            if (full_speed)
                            begin
                                speed_next = cur_max;
                            end
                            else
                            begin
                                div_start = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        speed_valid_next = 1'b1;
                        ph_new           = PH_START;
                    end
                endcase
            end
            if (dir_reg == DIR_UP)
            begin
                up_phase_next = ph_new;
                up_ticks_next = tk_new;
            end
            else
            begin
                down_phase_next = ph_new;
                down_ticks_next = tk_new;
            end
        end
        else if (state_reg == S_DIV && div_done)
        begin
            speed_next = div_quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dir_reg        <= DIR_UP;
            up_phase_reg   <= PH_IDLE;
            down_phase_reg <= PH_IDLE;
            up_ticks_reg   <= '0;
            down_ticks_reg <= '0;
            up_max_reg     <= '0;
            up_ramp_reg    <= RAMP_RESET;
            down_max_reg   <= '0;
            down_ramp_reg  <= RAMP_RESET;
            guard_en_reg   <= 1'b0;
            guard_thr_reg  <= THRESH_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            dir_reg        <= dir_next;
            up_phase_reg   <= up_phase_next;
            down_phase_reg <= down_phase_next;
            up_ticks_reg   <= up_ticks_next;
            down_ticks_reg <= down_ticks_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_UP_MAX:    up_max_reg    <= cfg_data[SPEED_W-1:0];
                    REG_UP_RAMP:   up_ramp_reg   <= cfg_data[RAMP_W-1:0];
                    REG_DOWN_MAX:  down_max_reg  <= cfg_data[SPEED_W-1:0];
                    REG_DOWN_RAMP: down_ramp_reg <= cfg_data[RAMP_W-1:0];
                    REG_GUARD_EN:  guard_en_reg  <= cfg_data[0];
                    REG_GUARD_THR: guard_thr_reg <= cfg_data[THRESH_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            up_held_reg   <= up_held;
            down_held_reg <= down_held;
            mag_reg       <= mag_in;
        end
        speed_valid_reg <= speed_valid_next;
        speed_reg       <= speed_next;
        start_reg       <= start_next;
        stop_reg        <= stop_next;
        trip_reg        <= trip_next;
        last_reg        <= last_next;
    end

    assign direction   = dir_reg;
    assign speed_valid = speed_valid_reg;
    assign speed_cmd   = speed_reg;
    assign start_pulse = start_reg;
    assign stop_pulse  = stop_reg;
    assign guard_trip  = trip_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// testbench for the jog speed ramp with load guard: randomized jog ticks and register settings,
// results checked against an in-bench predictor of both direction sequencers
// depends on rtl/jsr_pkg.sv and rtl/jog_speed_ramp_with_load_guard_top.sv
`timescale 1ns / 1ps

module tb_top;
    import jsr_pkg::*;

    localparam int TICK_BITS = 16;
    localparam int SETTLE_CYCLES = 48;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int RANDOM_PHASES = 8;
    localparam int LONG_HOLD_CYCLES = 400;

    // indexes past the register file, writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    localparam logic [LOAD_W-1:0] LOAD_MOST_NEG = {1'b1, {(LOAD_W-1){1'b0}}};
    localparam logic [LOAD_W-1:0] LOAD_MOST_POS = {1'b0, {(LOAD_W-1){1'b1}}};
    localparam logic [CFG_DATA_W-1:0] CFG_ONES = {CFG_DATA_W{1'b1}};

    typedef struct packed {
        logic              up;
        logic              down;
        logic [LOAD_W-1:0] load;
    } jog_tick_t;

    typedef struct packed {
        logic               direction;
        logic               speed_valid;
        logic [SPEED_W-1:0] speed_cmd;
        logic               start_pulse;
        logic               stop_pulse;
        logic               guard_trip;
        logic               last;
    } jog_result_t;

    typedef enum logic [1:0] {
        NO_STALL    = 2'd0,
        HALF_STALL  = 2'd1,
        LIGHT_STALL = 2'd2,
        HEAVY_STALL = 2'd3
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic up_held = 1'b0;
    logic down_held = 1'b0;
    logic signed [LOAD_W-1:0] load_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic direction;
    logic speed_valid;
    logic [SPEED_W-1:0] speed_cmd;
    logic start_pulse;
    logic stop_pulse;
    logic guard_trip;
    logic last;

    // predictor copy of the registers and of both sequencers, index is the direction
    logic [SPEED_W-1:0] top_speed [2];
    logic [RAMP_W-1:0] ramp_secs [2];
    logic guard_on;
    logic [THRESH_W-1:0] trip_level;
    phase_t seq_phase [2];
    logic [TICK_BITS-1:0] seq_ticks [2];

    jog_tick_t pending_ticks[$];
    jog_result_t due_results[$];
    jog_tick_t cur_tick;
    int beats_due = 0;
    int beats_seen = 0;
    int mismatches = 0;

    int burst_left = 16;
    int gap_left = 0;
    logic drain_req = 1'b0;

    stall_mode_t stall_mode = NO_STALL;
    int mode_left = 0;
    int hold_left = 0;
    int holds_taken = 0;

    jog_speed_ramp_with_load_guard_top #(
        .TICK_COUNT_BITS(TICK_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .up_held(up_held),
        .down_held(down_held),
        .load_sample(load_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .direction(direction),
        .speed_valid(speed_valid),
        .speed_cmd(speed_cmd),
        .start_pulse(start_pulse),
        .stop_pulse(stop_pulse),
        .guard_trip(guard_trip),
        .last(last)
    );

    always #4 clk = ~clk;

    task automatic step_direction(input logic dir, input logic [LOAD_W:0] mag,
                                  input logic is_last);
        jog_result_t r;
        longint unsigned num;
        longint unsigned den;
        longint unsigned spd;
        r = '0;
        r.direction = dir;
        r.last = is_last;
        case (seq_phase[dir])
            PH_START:
            begin
                r.start_pulse = 1'b1;
                seq_phase[dir] = PH_RAMP;
            end
            PH_RAMP:
            begin
                if (seq_ticks[dir] != '1)
                    seq_ticks[dir] = seq_ticks[dir] + 1'b1;
                num = top_speed[dir];
                num = num * seq_ticks[dir];
                den = ramp_secs[dir];
                den = den * 10;
                if (den == 0)
                    spd = top_speed[dir];
                else
                begin
                    spd = num / den;
                    if (spd > top_speed[dir])
                        spd = top_speed[dir];
                end
                r.speed_valid = 1'b1;
                if (guard_on && mag >= trip_level)
                begin
                    r.stop_pulse = 1'b1;
                    r.guard_trip = 1'b1;
                    seq_phase[dir] = PH_IDLE;
                    seq_ticks[dir] = '0;
                end
                else
                    r.speed_cmd = SPEED_W'(spd);
            end
            default:
            begin
                r.speed_valid = 1'b1;
                seq_phase[dir] = PH_START;
            end
        endcase
        due_results.push_back(r);
    endtask

    task automatic predict_tick(input jog_tick_t t);
        logic [LOAD_W:0] mag;
        mag = {1'b0, t.load};
        if (t.load[LOAD_W-1])
            mag = {1'b1, {LOAD_W{1'b0}}} - mag;
        if (t.up)
            step_direction(DIR_UP, mag, !t.down);
        else
        begin
            seq_phase[DIR_UP] = PH_IDLE;
            seq_ticks[DIR_UP] = '0;
        end
        if (t.down)
            step_direction(DIR_DOWN, mag, 1'b1);
        else
        begin
            seq_phase[DIR_DOWN] = PH_IDLE;
            seq_ticks[DIR_DOWN] = '0;
        end
    endtask

    function automatic string fmt_result(input jog_result_t r);
        return $sformatf("dir=%0d sv=%0b spd=%0d start=%0b stop=%0b trip=%0b last=%0b",
                         r.direction, r.speed_valid, r.speed_cmd, r.start_pulse,
                         r.stop_pulse, r.guard_trip, r.last);
    endfunction

    task automatic log_mismatch(input string what, input string want, input jog_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected %s, got %s", $time, what, want, fmt_result(got));
    endtask

    // driver: bursts of ticks with random gaps, now and then waits for a full drain
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_tick(cur_tick);
                beats_due <= beats_due + int'(cur_tick.up) + int'(cur_tick.down);
                if (burst_left == 0)
                begin
                    gap_left = $urandom_range(0, 1) ? $urandom_range(1, 4)
                                                    : $urandom_range(5, 50);
                    burst_left = $urandom_range(1, 48);
                    drain_req = ($urandom_range(0, 15) == 0);
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (drain_req && beats_due != beats_seen)
                    in_valid <= 1'b0;
                else if (pending_ticks.size() != 0)
                begin
                    drain_req = 1'b0;
                    cur_tick = pending_ticks.pop_front();
                    up_held <= cur_tick.up;
                    down_held <= cur_tick.down;
                    load_sample <= cur_tick.load;
                    in_valid <= 1'b1;
                    burst_left--;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall pattern, with two long hold-offs along the way
    always @(posedge clk)
    begin
        jog_result_t got;
        jog_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = {direction, speed_valid, speed_cmd, start_pulse, stop_pulse,
                       guard_trip, last};
                if (due_results.size() == 0)
                    log_mismatch("unexpected result beat", "nothing", got);
                else
                begin
                    want = due_results.pop_front();
                    beats_seen <= beats_seen + 1;
                    if (got !== want)
                        log_mismatch("result mismatch", fmt_result(want), got);
                end
            end
            if (holds_taken < 2 && beats_seen >= (holds_taken + 1) * 700)
            begin
                hold_left = LONG_HOLD_CYCLES;
                holds_taken++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 200);
                end
                else
                    mode_left--;
                case (stall_mode)
                    NO_STALL:    out_stall <= 1'b0;
                    HALF_STALL:  out_stall <= ($urandom_range(0, 1) == 1);
                    LIGHT_STALL: out_stall <= ($urandom_range(0, 3) == 0);
                    default:     out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_UP_MAX:    top_speed[DIR_UP] = val[SPEED_W-1:0];
            REG_UP_RAMP:   ramp_secs[DIR_UP] = val[RAMP_W-1:0];
            REG_DOWN_MAX:  top_speed[DIR_DOWN] = val[SPEED_W-1:0];
            REG_DOWN_RAMP: ramp_secs[DIR_DOWN] = val[RAMP_W-1:0];
            REG_GUARD_EN:  guard_on = val[0];
            REG_GUARD_THR: trip_level = val[THRESH_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_tick(input logic u, input logic d, input logic [LOAD_W-1:0] load);
        pending_ticks.push_back({u, d, load});
    endtask

    // wait for every tick to be taken and every result to come back, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || beats_due != beats_seen)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [LOAD_W-1:0] pick_load(input logic [THRESH_W-1:0] level);
        logic [LOAD_W-1:0] m;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            m = (level > 1) ? LOAD_W'($urandom_range(0, level - 1)) : '0;
        else if (roll < 90)
            m = (level == 0) ? '0 : LOAD_W'(level - $urandom_range(0, 1));
        else if (roll < 96)
            return LOAD_W'($urandom);
        else
            return $urandom_range(0, 1) ? LOAD_MOST_NEG : LOAD_MOST_POS;
        if ($urandom_range(0, 1))
            m = ~m + 1'b1;
        return m;
    endfunction

    // mostly steady holds so the ramps get somewhere, plus noisy holds and releases
    task automatic queue_random_ticks(input int count);
        int left;
        int run;
        int kind;
        int sel;
        logic u;
        logic d;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                run = $urandom_range(3, 60);
                sel = $urandom_range(0, 2);
                u = (sel != 1);
                d = (sel != 0);
            end
            else if (kind < 9)
                run = $urandom_range(1, 10);
            else
                run = $urandom_range(1, 3);
            if (run > left)
                run = left;
            repeat (run)
            begin
                if (kind == 7 || kind == 8)
                begin
                    u = $urandom_range(0, 1);
                    d = $urandom_range(0, 1);
                end
                else if (kind == 9)
                begin
                    u = 1'b0;
                    d = 1'b0;
                end
                queue_tick(u, d, pick_load(trip_level));
            end
            left -= run;
        end
    endtask

    task automatic random_config(input int p);
        int unsigned roll;
        if (p == 0)
        begin
            write_reg(REG_UP_MAX, CFG_ONES);
            write_reg(REG_UP_RAMP, CFG_ONES);
            write_reg(REG_DOWN_MAX, '0);
            write_reg(REG_DOWN_RAMP, '0);
            write_reg(REG_GUARD_EN, '0);
            write_reg(REG_GUARD_THR, '0);
        end
        else if (p == 1)
        begin
            write_reg(REG_UP_MAX, '0);
            write_reg(REG_UP_RAMP, 1);
            write_reg(REG_DOWN_MAX, CFG_ONES);
            write_reg(REG_DOWN_RAMP, 1);
            write_reg(REG_GUARD_EN, 1);
            write_reg(REG_GUARD_THR, CFG_ONES);
        end
        else
        begin
            for (int i = 0; i < 2; i++)
            begin
                roll = $urandom_range(0, 4);
                write_reg(i ? REG_DOWN_MAX : REG_UP_MAX,
                          (roll == 0) ? '0 : (roll == 1) ? CFG_ONES :
                          (roll == 2) ? CFG_DATA_W'($urandom)
                                      : CFG_DATA_W'($urandom_range(1, 3000)));
                roll = $urandom_range(0, 5);
                write_reg(i ? REG_DOWN_RAMP : REG_UP_RAMP,
                          (roll == 0) ? '0 : (roll == 1) ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(1, 6)));
            end
            write_reg(REG_GUARD_EN, CFG_DATA_W'($urandom));
            roll = $urandom_range(0, 4);
            write_reg(REG_GUARD_THR, (roll == 0) ? '0 : (roll == 1) ? CFG_ONES :
                                     (roll == 2) ? CFG_DATA_W'($urandom)
                                                 : CFG_DATA_W'($urandom_range(0, 2000)));
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom));
        end
    endtask

    initial
    begin
        top_speed[DIR_UP] = '0;
        top_speed[DIR_DOWN] = '0;
        ramp_secs[DIR_UP] = RAMP_RESET;
        ramp_secs[DIR_DOWN] = RAMP_RESET;
        guard_on = 1'b0;
        trip_level = THRESH_RESET;
        seq_phase[DIR_UP] = PH_IDLE;
        seq_phase[DIR_DOWN] = PH_IDLE;
        seq_ticks[DIR_UP] = '0;
        seq_ticks[DIR_DOWN] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // register reset values: full sequence with zero top speed, then a release
        @(negedge clk);
        repeat (3) queue_tick(1'b1, 1'b1, '0);
        queue_tick(1'b0, 1'b0, '0);
        wait_idle();

        write_reg(REG_UP_MAX, CFG_ONES);
        write_reg(REG_UP_RAMP, '0);
        write_reg(REG_DOWN_MAX, 1000);
        write_reg(REG_DOWN_RAMP, 1);
        write_reg(REG_GUARD_EN, 1);
        write_reg(REG_GUARD_THR, 100);
        write_reg(REG_SPARE_A, '0);
        write_reg(REG_SPARE_B, CFG_ONES);
        @(negedge clk);
        // zero ramp on up, linear ramp on down, trip exactly at the threshold
        repeat (3) queue_tick(1'b1, 1'b1, '0);
        repeat (2) queue_tick(1'b1, 1'b1, 5);
        queue_tick(1'b1, 1'b1, LOAD_W'(-100));
        repeat (3) queue_tick(1'b1, 1'b1, 99);
        queue_tick(1'b1, 1'b0, 99);
        queue_tick(1'b1, 1'b0, LOAD_MOST_NEG);
        repeat (3) queue_tick(1'b0, 1'b1, LOAD_MOST_POS);
        wait_idle();

        // zero threshold with the guard on trips on every ramp tick
        write_reg(REG_GUARD_THR, '0);
        write_reg(REG_DOWN_RAMP, CFG_ONES);
        @(negedge clk);
        repeat (3) queue_tick(1'b0, 1'b1, '0);
        queue_tick(1'b1, 1'b1, '0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            random_config(p);
            @(negedge clk);
            queue_random_ticks(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
